### design/qra_pkg.sv
package qra_pkg;

  // Default configuration of the block.
  localparam int COMPONENT_BITS_DEF   = 16;
  localparam int ANGLE_ITERATIONS_DEF = 16;

  // Datapath widths after each scaling point.
  localparam int OP_W     = 17;  // scaled quaternion component, signed
  localparam int PROD_W   = 34;  // one partial product, signed
  localparam int SUM_W    = 36;  // Hamilton product component, signed
  localparam int PMAG_W   = 35;  // magnitude of a product component
  localparam int PSC_W    = 30;  // magnitude after product scaling
  localparam int P0_W     = 31;  // scaled scalar part, signed
  localparam int RAD_W    = 62;  // sum of the three squares
  localparam int ROOT_W   = 31;  // square root of that sum
  localparam int REM_W    = 34;  // square-root remainder
  localparam int CW       = 34;  // CORDIC x and y, signed
  localparam int ZW       = 28;  // CORDIC angle in 2^-24 rad, signed
  localparam int ANGLE_W  = 16;

  localparam int OP_LIMIT  = 16;
  localparam int SUM_LIMIT = 30;
  localparam int PSH_W     = 6;

  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic [ANGLE_W-1:0]   ANGLE_MAX   = 16'd51472;

  // Control bits that travel with every beat through the pipeline.
  typedef struct packed {
    logic valid;
    logic inv;
  } qra_ctl_t;

  // Arctangent of 2^-i in units of 2^-24 rad.
  function automatic logic signed [ZW-1:0] atan_val(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/quaternion_relative_angle.sv
// Relative rotation angle of two Q2.14 quaternions, given as twice atan2 of the
// vector-part length and the scalar part of second * conj(first), in unsigned
// Q3.13. A beat is taken on every cycle in which start is high (busy stays
// low), so one pair per clock is sustained. Each result appears on done_o
// after its start beat has passed eight stages of scaling, product and squares,
// 31 stages of the bit-per-stage square root, one CORDIC setup stage, one stage
// per CORDIC iteration and an output register.
// The receiver cannot stall; it must take each result in the cycle it is shown.
// An all-zero quaternion on either side gives invalid_o high with angle 0.
module quaternion_relative_angle #(
  parameter int COMPONENT_BITS   = qra_pkg::COMPONENT_BITS_DEF,
  parameter int ANGLE_ITERATIONS = qra_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COMPONENT_BITS-1:0] first_w_i,
  input  logic signed [COMPONENT_BITS-1:0] first_x_i,
  input  logic signed [COMPONENT_BITS-1:0] first_y_i,
  input  logic signed [COMPONENT_BITS-1:0] first_z_i,
  input  logic signed [COMPONENT_BITS-1:0] second_w_i,
  input  logic signed [COMPONENT_BITS-1:0] second_x_i,
  input  logic signed [COMPONENT_BITS-1:0] second_y_i,
  input  logic signed [COMPONENT_BITS-1:0] second_z_i,
  output logic                             done_o,
  output logic [qra_pkg::ANGLE_W-1:0]      angle_o,
  output logic                             invalid_o
);
  import qra_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int SW = $clog2(CB + 1);

  // The pipeline never holds, so a beat is taken whenever start is high.
  assign busy = 1'b0;

  logic signed [CB-1:0] comp [8];
  assign comp[0] = first_w_i;
  assign comp[1] = first_x_i;
  assign comp[2] = first_y_i;
  assign comp[3] = first_z_i;
  assign comp[4] = second_w_i;
  assign comp[5] = second_x_i;
  assign comp[6] = second_y_i;
  assign comp[7] = second_z_i;

  // Stage 1: magnitudes and the operand shift of each quaternion.
  logic [CB-1:0] mag_d [8];
  logic [CB-1:0] orv   [2];
  logic [SW-1:0] len   [2];
  logic [SW-1:0] sh_d  [2];
  logic          inv_d;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mag_d[k] = comp[k][CB-1] ? CB'(-comp[k]) : CB'(comp[k]);
    end
    for (int q = 0; q < 2; q++) begin
      orv[q] = mag_d[4*q] | mag_d[4*q+1] | mag_d[4*q+2] | mag_d[4*q+3];
      len[q] = '0;
      for (int i = 0; i < CB; i++) begin
        if (orv[q][i]) begin
          len[q] = SW'(i + 1);
        end
      end
      sh_d[q] = (int'(len[q]) > OP_LIMIT) ? SW'(int'(len[q]) - OP_LIMIT) : '0;
    end
    inv_d = (orv[0] == '0) || (orv[1] == '0);
  end

  qra_ctl_t      ctl1_q;
  logic [CB-1:0] mag_q [8];
  logic          neg_q [8];
  logic [SW-1:0] sh_q  [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q <= '{valid: start, inv: inv_d};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 8; k++) begin
      mag_q[k] <= mag_d[k];
      neg_q[k] <= comp[k][CB-1];
    end
    sh_q[0] <= sh_d[0];
    sh_q[1] <= sh_d[1];
  end

  // Stage 2: scaled operands with the sign restored.
  qra_ctl_t               ctl2_q;
  logic signed [OP_W-1:0] op_q [8];
  logic [CB-1:0]          smag [8];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      smag[k] = mag_q[k] >> sh_q[k/4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 8; k++) begin
      op_q[k] <= neg_q[k] ? -OP_W'(smag[k]) : OP_W'(smag[k]);
    end
  end

  // Stage 3: all sixteen partial products a[i] * b[j].
  qra_ctl_t                 ctl3_q;
  logic signed [PROD_W-1:0] pr_q [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else begin
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pr_q[4*i+j] <= PROD_W'(op_q[i] * op_q[4+j]);
      end
    end
  end

  // Stage 4: Hamilton product of the second with the conjugate of the first.
  qra_ctl_t                ctl4_q;
  logic signed [SUM_W-1:0] p_q [4];
  logic signed [SUM_W-1:0] pe  [16];

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      pe[k] = SUM_W'(pr_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else begin
      ctl4_q <= ctl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= pe[0]  + pe[5]  + pe[10] + pe[15];
    p_q[1] <= pe[1]  - pe[4]  + pe[11] - pe[14];
    p_q[2] <= pe[2]  - pe[7]  - pe[8]  + pe[13];
    p_q[3] <= pe[3]  + pe[6]  - pe[9]  - pe[12];
  end

  // Stage 5: magnitudes of the product and its shift amount.
  logic [PMAG_W-1:0] pm_d [4];
  logic [PMAG_W-1:0] por;
  logic [PSH_W-1:0]  plen;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pm_d[k] = (p_q[k] < 0) ? PMAG_W'(-p_q[k]) : PMAG_W'(p_q[k]);
    end
    por  = pm_d[0] | pm_d[1] | pm_d[2] | pm_d[3];
    plen = '0;
    for (int i = 0; i < PMAG_W; i++) begin
      if (por[i]) begin
        plen = PSH_W'(i + 1);
      end
    end
  end

  qra_ctl_t          ctl5_q;
  logic [PMAG_W-1:0] pm_q [4];
  logic              p0neg_q;
  logic [PSH_W-1:0]  psh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl5_q <= '0;
    end else begin
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      pm_q[k] <= pm_d[k];
    end
    p0neg_q <= p_q[0] < 0;
    psh_q   <= (int'(plen) > SUM_LIMIT) ? PSH_W'(int'(plen) - SUM_LIMIT) : '0;
  end

  // Stage 6: scaled product components.
  qra_ctl_t               ctl6_q;
  logic signed [P0_W-1:0] p0s_q;
  logic [PSC_W-1:0]       vs_q [3];
  logic [PMAG_W-1:0]      p0m;

  assign p0m = pm_q[0] >> psh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl6_q <= '0;
    end else begin
      ctl6_q <= ctl5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0s_q <= p0neg_q ? -P0_W'(p0m) : P0_W'(p0m);
    for (int k = 0; k < 3; k++) begin
      vs_q[k] <= PSC_W'(pm_q[k+1] >> psh_q);
    end
  end

  // Stage 7: squares of the vector part.
  qra_ctl_t               ctl7_q;
  logic signed [P0_W-1:0] p07_q;
  logic [2*PSC_W-1:0]     sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl7_q <= '0;
    end else begin
      ctl7_q <= ctl6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p07_q <= p0s_q;
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= vs_q[k] * vs_q[k];
    end
  end

  // Stage 8: squared length of the vector part.
  qra_ctl_t               ctl8_q;
  logic signed [P0_W-1:0] p08_q;
  logic [RAD_W-1:0]       rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl8_q <= '0;
    end else begin
      ctl8_q <= ctl7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p08_q <= p07_q;
    rad_q <= RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]) + RAD_W'(sq_q[2]);
  end

  // Vector length, then the arctangent.
  qra_ctl_t               sq_ctl;
  logic signed [P0_W-1:0] sq_p0;
  logic [ROOT_W-1:0]      sq_root;
  qra_ctl_t               cd_ctl;
  logic signed [ZW-1:0]   cd_z;

  qra_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl8_q),
    .p0_i   (p08_q),
    .rad_i  (rad_q),
    .ctl_o  (sq_ctl),
    .p0_o   (sq_p0),
    .root_o (sq_root)
  );

  qra_cordic #(
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .p0_i   (sq_p0),
    .root_i (sq_root),
    .ctl_o  (cd_ctl),
    .z_o    (cd_z)
  );

  // Output: double, round to Q3.13 and clamp to the 0 to 2*pi range; an invalid pair gives 0.
  logic signed [ZW+1:0] zr;
  logic signed [ZW+1:0] t;
  logic [ANGLE_W-1:0]   angle_d;

  always_comb begin
    zr = ((ZW+2)'(cd_z) <<< 1) + (ZW+2)'(1024);
    t  = zr >>> 11;
    if (cd_ctl.inv || t < 0) begin
      angle_d = '0;
    end else if (t > (ZW+2)'(ANGLE_MAX)) begin
      angle_d = ANGLE_MAX;
    end else begin
      angle_d = ANGLE_W'(t);
    end
  end

  logic               done_q;
  logic [ANGLE_W-1:0] angle_q;
  logic               invalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cd_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q   <= angle_d;
    invalid_q <= cd_ctl.inv;
  end

  assign done_o    = done_q;
  assign angle_o   = angle_q;
  assign invalid_o = invalid_q;

endmodule

### design/qra_sqrt.sv
module qra_sqrt (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  qra_pkg::qra_ctl_t                    ctl_i,
  input  logic signed [qra_pkg::P0_W-1:0]      p0_i,
  input  logic [qra_pkg::RAD_W-1:0]            rad_i,
  output qra_pkg::qra_ctl_t                    ctl_o,
  output logic signed [qra_pkg::P0_W-1:0]      p0_o,
  output logic [qra_pkg::ROOT_W-1:0]           root_o
);
  import qra_pkg::*;

  // One result bit per stage, two radicand bits consumed per stage.
  qra_ctl_t                ctl_q  [ROOT_W];
  logic signed [P0_W-1:0]  p0_q   [ROOT_W];
  logic [RAD_W-1:0]        rad_q  [ROOT_W];
  logic [REM_W-1:0]        rem_q  [ROOT_W];
  logic [ROOT_W-1:0]       root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    qra_ctl_t               ctl_in;
    logic signed [P0_W-1:0] p0_in;
    logic [RAD_W-1:0]       rad_in;
    logic [REM_W-1:0]       rem_in;
    logic [ROOT_W-1:0]      root_in;
    logic [REM_W+1:0]       trial;
    logic [REM_W+1:0]       sub;
    logic                   ge;

    if (k == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign p0_in   = p0_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign ctl_in  = ctl_q[k-1];
      assign p0_in   = p0_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Restoring step: try to subtract 4*root + 1 from the shifted remainder.
    assign trial = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign sub   = (REM_W+2)'({root_in, 2'b01});
    assign ge    = (trial >= sub);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      p0_q[k]   <= p0_in;
      rad_q[k]  <= rad_in << 2;
      rem_q[k]  <= ge ? REM_W'(trial - sub) : REM_W'(trial);
      root_q[k] <= {root_in[ROOT_W-2:0], ge};
    end
  end

  assign ctl_o  = ctl_q[ROOT_W-1];
  assign p0_o   = p0_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];

endmodule

### design/qra_cordic.sv
module qra_cordic #(
  parameter int ANGLE_ITERATIONS = qra_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  qra_pkg::qra_ctl_t                 ctl_i,
  input  logic signed [qra_pkg::P0_W-1:0]   p0_i,
  input  logic [qra_pkg::ROOT_W-1:0]        root_i,
  output qra_pkg::qra_ctl_t                 ctl_o,
  output logic signed [qra_pkg::ZW-1:0]     z_o
);
  import qra_pkg::*;

  localparam int N = ANGLE_ITERATIONS + 1;

  qra_ctl_t              ctl_q [N];
  logic signed [CW-1:0]  x_q   [N];
  logic signed [CW-1:0]  y_q   [N];
  logic signed [ZW-1:0]  z_q   [N];

  // Setup stage: a negative scalar part is rotated by a quarter turn first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p0_i < 0) begin
      x_q[0] <= CW'(root_i);
      y_q[0] <= -CW'(p0_i);
      z_q[0] <= HALF_PI_Q24;
    end else begin
      x_q[0] <= CW'(p0_i);
      y_q[0] <= CW'(root_i);
      z_q[0] <= '0;
    end
  end

  // Vectoring iterations, one micro-rotation per stage.
  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_iter
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i+1] <= '0;
      end else begin
        ctl_q[i+1] <= ctl_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (y_q[i] > 0) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + atan_val(i);
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - atan_val(i);
      end
    end
  end

  assign ctl_o = ctl_q[N-1];
  assign z_o   = z_q[N-1];

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import qra_pkg::*;

  localparam int NB = 16;
  localparam int LATENCY = 41 + ANGLE_ITERATIONS_DEF;

  // One pair of quaternions: w, x, y, z of the first, then of the second.
  typedef struct {
    logic signed [NB-1:0] c [8];
  } quat_pair_t;

  typedef struct {
    logic [ANGLE_W-1:0] angle;
    logic               inv;
  } angle_res_t;

  // Predicts the relative angle of each accepted pair and checks results in order.
  class angle_scoreboard;
    angle_res_t pending[$];
    int         errors;

    function automatic longint unsigned umag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic int bit_len(longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
        n++;
        v >>= 1;
      end
      return n;
    endfunction

    // Shrinks all four magnitudes by the same amount so the largest fits in lim bits.
    function automatic void fit4(ref longint q[4], input int lim);
      longint unsigned mx;
      int len;
      longint unsigned m;
      mx = 0;
      for (int i = 0; i < 4; i++) if (umag(q[i]) > mx) mx = umag(q[i]);
      len = bit_len(mx);
      if (len > lim) begin
        for (int i = 0; i < 4; i++) begin
          m = umag(q[i]) >> (len - lim);
          q[i] = q[i] < 0 ? -longint'(m) : longint'(m);
        end
      end
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic longint atan_step(int i);
      longint t [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                         131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2};
      return t[i];
    endfunction

    function automatic angle_res_t relative_angle(quat_pair_t q);
      longint a[4], b[4], p[4];
      longint cx, cy, cz, nx, ny, t;
      longint unsigned m;
      bit az, bz;
      angle_res_t r;
      az = 1;
      bz = 1;
      for (int i = 0; i < 4; i++) begin
        a[i] = q.c[i];
        b[i] = q.c[4+i];
        if (a[i] != 0) az = 0;
        if (b[i] != 0) bz = 0;
      end
      if (az || bz) begin
        r.angle = '0;
        r.inv = 1'b1;
        return r;
      end
      fit4(a, OP_LIMIT);
      fit4(b, OP_LIMIT);
      // Hamilton product b * conj(a).
      p[0] = a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3];
      p[1] = a[0]*b[1] - a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
      p[2] = a[0]*b[2] - a[1]*b[3] - a[2]*b[0] + a[3]*b[1];
      p[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] - a[3]*b[0];
      fit4(p, SUM_LIMIT);
      m = int_sqrt(umag(p[1])*umag(p[1]) + umag(p[2])*umag(p[2]) + umag(p[3])*umag(p[3]));
      // CORDIC vectoring; a negative scalar part starts a quarter turn ahead.
      if (p[0] < 0) begin
        cx = longint'(m);
        cy = -p[0];
        cz = HALF_PI_Q24;
      end else begin
        cx = p[0];
        cy = longint'(m);
        cz = 0;
      end
      for (int i = 0; i < ANGLE_ITERATIONS_DEF && i < 24; i++) begin
        if (cy > 0) begin
          nx = cx + (cy >>> i);
          ny = cy - (cx >>> i);
          cz += atan_step(i);
        end else begin
          nx = cx - (cy >>> i);
          ny = cy + (cx >>> i);
          cz -= atan_step(i);
        end
        cx = nx;
        cy = ny;
      end
      t = (2*cz + 1024) >>> 11;
      if (t < 0) t = 0;
      if (t > ANGLE_MAX) t = ANGLE_MAX;
      r.angle = t[ANGLE_W-1:0];
      r.inv = 1'b0;
      return r;
    endfunction

    function void note_pair(quat_pair_t q);
      pending.push_back(relative_angle(q));
    endfunction

    function void check_result(logic [ANGLE_W-1:0] angle, logic inv);
      angle_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: angle %0d invalid %0d", angle, inv);
        return;
      end
      e = pending.pop_front();
      if (angle !== e.angle || inv !== e.inv) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected angle %0d invalid %0d, got angle %0d invalid %0d",
                   e.angle, e.inv, angle, inv);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic signed [NB-1:0] fld [8];
  logic                 done_o;
  logic [ANGLE_W-1:0]   angle_o;
  logic                 invalid_o;

  angle_scoreboard sb;
  int              idle_pct;

  quaternion_relative_angle dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .first_w_i  (fld[0]),
    .first_x_i  (fld[1]),
    .first_y_i  (fld[2]),
    .first_z_i  (fld[3]),
    .second_w_i (fld[4]),
    .second_x_i (fld[5]),
    .second_y_i (fld[6]),
    .second_z_i (fld[7]),
    .done_o     (done_o),
    .angle_o    (angle_o),
    .invalid_o  (invalid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results are checked at the edge that ends their cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(angle_o, invalid_o);
  end

  // Drives one beat, with random idle cycles ahead of it, and waits for its acceptance.
  task automatic send_pair(quat_pair_t q);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      for (int i = 0; i < 8; i++) fld[i] = NB'($urandom);
    end
    @(negedge clk_i);
    start = 1'b1;
    fld = q.c;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
    sb.note_pair(q);
  endtask

  function automatic quat_pair_t random_pair();
    quat_pair_t q;
    int k;
    k = $urandom_range(9);
    for (int i = 0; i < 8; i++) begin
      case (k)
        0, 1, 2: q.c[i] = NB'($urandom);
        3:       q.c[i] = NB'(int'($urandom_range(200)) - 100);
        4:       q.c[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        default: q.c[i] = NB'(int'($urandom_range(32767)) - 16384);
      endcase
    end
    // Near-equal rotations give small angles; a zero quaternion now and then.
    if (k >= 7) for (int i = 0; i < 4; i++)
      q.c[4+i] = q.c[i] + NB'(int'($urandom_range(64)) - 32);
    if ($urandom_range(19) == 0) begin
      if ($urandom_range(1)) for (int i = 0; i < 4; i++) q.c[i] = '0;
      else for (int i = 0; i < 4; i++) q.c[4+i] = '0;
    end
    return q;
  endfunction

  function automatic quat_pair_t make_pair(int w1, int x1, int y1, int z1,
                                           int w2, int x2, int y2, int z2);
    quat_pair_t q;
    q.c = '{NB'(w1), NB'(x1), NB'(y1), NB'(z1), NB'(w2), NB'(x2), NB'(y2), NB'(z2)};
    return q;
  endfunction

  initial begin
    int cnt;
    sb = new();
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    for (int i = 0; i < 8; i++) fld[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero quaternions, identity, opposite, extremes, quarter turns.
    send_pair(make_pair(0, 0, 0, 0, 16384, 0, 0, 0));
    send_pair(make_pair(16384, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0));
    send_pair(make_pair(16384, 0, 0, 0, -16384, 0, 0, 0));
    send_pair(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0));
    send_pair(make_pair(16384, 0, 0, 0, 11585, 0, 11585, 0));
    send_pair(make_pair(16384, 0, 0, 0, 11585, 0, 0, -11585));
    send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(make_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
    send_pair(make_pair(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768));
    send_pair(make_pair(1, 0, 0, 0, 0, 0, 0, -1));
    send_pair(make_pair(0, 0, 0, 1, -1, 0, 0, 0));
    send_pair(make_pair(-1, -1, -1, -1, 1, 1, 1, 1));
    send_pair(make_pair(16384, 0, 0, 0, 16383, 1, 0, 0));
    send_pair(make_pair(16384, 0, 0, 0, -16383, 1, 0, 0));

    // Random phases: back to back, sparse sender, back to back again, then moderately sparse.
    cnt = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 80 : (ph == 3) ? 25 : 0;
      repeat (250) send_pair(random_pair());
    end
    @(negedge clk_i);
    start = 1'b0;

    while (sb.pending.size() != 0 && cnt < 10 * LATENCY) begin
      @(posedge clk_i);
      cnt++;
    end
    repeat (LATENCY + 5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("quaternion_relative_angle regression: pass");
    end else begin
      $display("quaternion_relative_angle regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("quaternion_relative_angle regression: fail");
    $finish;
  end

endmodule
